[hdl/btlpm_pkg.sv]
// Shared types and constants for the binary trie longest prefix match core.
package btlpm_pkg;

   localparam int NODE_COUNT = 4096;
   localparam int ADDR_BITS  = 32;
   localparam int PORT_BITS  = 8;

   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int FREE_BITS  = $clog2(NODE_COUNT + 1);
   localparam int LEVEL_BITS = $clog2(ADDR_BITS + 1);

   localparam int ADDRESS_W  = 32;
   localparam int PLEN_W     = 6;
   localparam int RPORT_W    = 8;
   localparam int OUT_PORT_W = 8;
   localparam int STATUS_W   = 2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic                 opcode;
      logic [ADDRESS_W-1:0] address;
      logic [PLEN_W-1:0]    prefix_length;
      logic [RPORT_W-1:0]   route_port;
   } req_type;

   typedef struct packed {
      logic [OUT_PORT_W-1:0] out_port;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] left;
      logic [NODE_BITS-1:0] right;
      logic                 route;
      logic [PORT_BITS-1:0] port;
   } node_type;

   typedef struct packed {
      logic load;
      logic walk;
   } cmd_type;

   typedef struct packed {
      logic finish;
   } stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

[hdl/btlpm_ctrl.sv]
// Controller state machine: sequences one trie walk per accepted operation.
module btlpm_ctrl
   import btlpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (stat.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.walk = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_WALK: begin
            busy     = 1'b1;
            cmd.walk = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

endmodule

[hdl/btlpm_datapath.sv]
// Datapath: node memory, root node registers, walk registers and result register.
module btlpm_datapath
   import btlpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp
);

   node_type mem [NODE_COUNT];
   node_type rd_data_ff;
   node_type root_ff, root_in;

   logic                 op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [LEVEL_BITS-1:0] len_ff, len_in;
   logic [PORT_BITS-1:0] port_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [NODE_BITS-1:0] cur_ff;
   logic                 cur_root_ff;
   logic                 cur_fresh_ff;
   logic [PORT_BITS-1:0] best_ff;
   logic                 matched_ff;
   logic [FREE_BITS-1:0] free_ff;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff, rsp_in;

   node_type             node, wr_node;
   logic                 dir;
   logic [NODE_BITS-1:0] child, nxt_idx;
   logic                 hit, match_now, lk_end;
   logic [PORT_BITS-1:0] best_now;
   logic                 ins_mark, ins_need, ins_full;
   logic                 finish, advance, wr_en;

   // Current node: the root lives in registers, a freshly allocated node is empty.
   always_comb begin
      if (cur_root_ff) begin
         node = root_ff;
      end else if (cur_fresh_ff) begin
         node = '0;
      end else begin
         node = rd_data_ff;
      end
   end

   always_comb begin
      dir       = addr_ff[ADDR_BITS-1];
      child     = dir ? node.right : node.left;
      hit       = node.route;
      best_now  = hit ? node.port : best_ff;
      match_now = hit | matched_ff;
      lk_end    = (level_ff == LEVEL_BITS'(ADDR_BITS)) || (child == '0);
      ins_mark  = (level_ff == len_ff);
      ins_need  = !ins_mark && (child == '0);
      ins_full  = ins_need && (free_ff == FREE_BITS'(NODE_COUNT));
      finish    = (op_ff == OP_INSERT) ? (ins_mark || ins_full) : lk_end;
      advance   = cmd.walk && !finish;
      nxt_idx   = (child == '0) ? free_ff[NODE_BITS-1:0] : child;
   end

   // Node update for an insert; a full pool writes the node back unchanged so
   // that an empty node allocated earlier in this insert is stored cleared.
   always_comb begin
      wr_node = node;
      wr_en   = 1'b0;
      if (cmd.walk && (op_ff == OP_INSERT)) begin
         if (ins_mark) begin
            wr_node.route = 1'b1;
            wr_node.port  = port_ff;
            wr_en         = 1'b1;
         end else if (ins_full) begin
            wr_en = 1'b1;
         end else if (ins_need) begin
            if (dir) begin
               wr_node.right = free_ff[NODE_BITS-1:0];
            end else begin
               wr_node.left = free_ff[NODE_BITS-1:0];
            end
            wr_en = 1'b1;
         end
      end
   end

   always_comb begin
      root_in = root_ff;
      if (wr_en && cur_root_ff) begin
         root_in = wr_node;
      end
   end

   always_comb begin
      if (req.prefix_length > PLEN_W'(ADDR_BITS)) begin
         len_in = LEVEL_BITS'(ADDR_BITS);
      end else begin
         len_in = LEVEL_BITS'(req.prefix_length);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (op_ff == OP_INSERT) begin
         if (ins_mark) begin
            rsp_in.out_port = OUT_PORT_W'(port_ff);
            rsp_in.status   = STAT_OK;
         end else begin
            rsp_in.out_port = '0;
            rsp_in.status   = STAT_FULL;
         end
      end else begin
         rsp_in.out_port = OUT_PORT_W'(best_now);
         rsp_in.status   = match_now ? STAT_OK : STAT_NOMATCH;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[nxt_idx];
      if (wr_en && !cur_root_ff) begin
         mem[cur_ff] <= wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         free_ff       <= FREE_BITS'(1);
         rsp_strobe_ff <= 1'b0;
         cur_root_ff   <= 1'b1;
         cur_fresh_ff  <= 1'b0;
      end else begin
         root_ff       <= root_in;
         rsp_strobe_ff <= cmd.walk && finish;
         if (cmd.load) begin
            cur_root_ff  <= 1'b1;
            cur_fresh_ff <= 1'b0;
         end else if (advance) begin
            cur_root_ff  <= 1'b0;
            cur_fresh_ff <= (op_ff == OP_INSERT) && ins_need;
            if ((op_ff == OP_INSERT) && ins_need) begin
               free_ff <= free_ff + FREE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req.opcode;
         addr_ff    <= req.address[ADDR_BITS-1:0];
         len_ff     <= len_in;
         port_ff    <= PORT_BITS'(req.route_port);
         level_ff   <= '0;
         cur_ff     <= '0;
         best_ff    <= '0;
         matched_ff <= 1'b0;
      end else if (advance) begin
         addr_ff    <= {addr_ff[ADDR_BITS-2:0], 1'b0};
         level_ff   <= level_ff + LEVEL_BITS'(1);
         cur_ff     <= nxt_idx;
         best_ff    <= best_now;
         matched_ff <= match_now;
      end
      if (cmd.walk && finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.finish = finish;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp         = rsp_ff;

endmodule

[hdl/binary_trie_longest_prefix_match_core.sv]
// Result: the result and its strobe are registered from the last walk step, after L trie
// levels have been walked (L from 0 to 32); the receiver cannot stall.
// Operations: one at a time; a new start transfer is taken only once the walk of the last
// has finished, as the single read port of the node memory serves one trie level at a time.
// Reset: synchronous; it empties the root node and resets the allocation pointer to 1.
// Entries other than the root are cleared when they are allocated, so no clearing pass.
module binary_trie_longest_prefix_match_core
   import btlpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // Command and status between the controller and the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller accepts a transfer when start is high and no walk is in
   // progress, then steps one trie level per cycle until the datapath reports
   // that the walk has finished.
   btlpm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // The datapath holds the node memory and the root node registers. A lookup
   // follows the address bits and remembers the port of the deepest route end
   // passed; an insert allocates missing nodes and marks the final node.
   btlpm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule
